FILE: hdl/sef_pkg.sv
package sef_pkg;

  localparam logic [2:0] REQ_COMMENT = 3'd0;
  localparam logic [2:0] REQ_EVENT   = 3'd1;
  localparam logic [2:0] REQ_ID      = 3'd2;
  localparam logic [2:0] REQ_RETRY   = 3'd3;
  localparam logic [2:0] REQ_DATA    = 3'd4;
  localparam logic [2:0] REQ_END     = 3'd5;

  // open field code is the request type plus one
  localparam logic [2:0] FLD_NONE    = 3'd0;
  localparam logic [2:0] FLD_COMMENT = 3'd1;
  localparam logic [2:0] FLD_EVENT   = 3'd2;
  localparam logic [2:0] FLD_RETRY   = 3'd4;
  localparam logic [2:0] FLD_DATA    = 3'd5;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  // strings left-justified in seven byte slots
  localparam logic [55:0] STR_EVENT      = "event: ";
  localparam logic [55:0] STR_ID         = {"id: ", 24'h0};
  localparam logic [55:0] STR_RETRY      = "retry: ";
  localparam logic [55:0] STR_DATA_TXT   = {"data: ", 8'h0};
  localparam logic [55:0] STR_CMT_TXT    = {": ", 40'h0};
  localparam logic [55:0] STR_DATA_EMPTY = {"data:", CH_LF, 8'h0};
  localparam logic [55:0] STR_CMT_EMPTY  = {":", CH_LF, 40'h0};

  typedef enum logic [3:0] {
    P_NONE,
    P_EVENT_PFX,
    P_ID_PFX,
    P_RETRY_PFX,
    P_DATA_TXT,
    P_CMT_TXT,
    P_BYTE,
    P_LF,
    P_DATA_EMPTY,
    P_CMT_EMPTY,
    P_REJECT
  } piece_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       last_of_field;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       reject;
  } out_item_t;

  // output of one input item: pieces packed from slot 0, unused slots are P_NONE
  typedef struct packed {
    piece_e [NumSlots-1:0] pcs;
    logic [7:0]            data;
  } cmd_t;

  function automatic logic [2:0] piece_len(piece_e p);
    logic [2:0] len;
    unique case (p)
      P_EVENT_PFX:  len = 3'd7;
      P_ID_PFX:     len = 3'd4;
      P_RETRY_PFX:  len = 3'd7;
      P_DATA_TXT:   len = 3'd6;
      P_CMT_TXT:    len = 3'd2;
      P_DATA_EMPTY: len = 3'd6;
      P_CMT_EMPTY:  len = 3'd2;
      default:      len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] str_byte(logic [55:0] s, logic [2:0] idx);
    logic [5:0] pos;
    pos = {3'd6 - idx, 3'b000};
    return s[pos +: 8];
  endfunction

  function automatic logic [7:0] piece_char(piece_e p, logic [2:0] idx, logic [7:0] data);
    logic [7:0] ch;
    unique case (p)
      P_EVENT_PFX:  ch = str_byte(STR_EVENT, idx);
      P_ID_PFX:     ch = str_byte(STR_ID, idx);
      P_RETRY_PFX:  ch = str_byte(STR_RETRY, idx);
      P_DATA_TXT:   ch = str_byte(STR_DATA_TXT, idx);
      P_CMT_TXT:    ch = str_byte(STR_CMT_TXT, idx);
      P_DATA_EMPTY: ch = str_byte(STR_DATA_EMPTY, idx);
      P_CMT_EMPTY:  ch = str_byte(STR_CMT_EMPTY, idx);
      P_BYTE:       ch = data;
      P_LF:         ch = CH_LF;
      default:      ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/sef_front.sv
module sef_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sef_pkg::in_item_t item_i,
  input  logic              accept_i,
  output logic              wr_en_o,
  output sef_pkg::cmd_t     wr_cmd_o
);

  typedef struct packed {
    sef_pkg::cmd_t cmd;
    logic [2:0]    n;
  } build_t;

  logic [2:0] cur_field_q, cur_field_d;
  logic       line_open_q, line_open_d;
  logic       seg_ne_q, seg_ne_d;
  logic       after_cr_q, after_cr_d;
  logic       any_q, any_d;
  logic       rej_q, rej_d;
  build_t     bld;

  function automatic build_t add_piece(build_t b, sef_pkg::piece_e p);
    build_t r;
    r = b;
    if (p != sef_pkg::P_NONE && b.n < 3'(sef_pkg::NumSlots)) begin
      r.cmd.pcs[b.n[sef_pkg::SlotW-1:0]] = p;
      r.n = b.n + 3'd1;
    end
    return r;
  endfunction

  function automatic sef_pkg::piece_e close_piece(logic [2:0] cf, logic sn);
    sef_pkg::piece_e p;
    if (cf == sef_pkg::FLD_COMMENT || cf == sef_pkg::FLD_DATA) begin
      if (sn) p = sef_pkg::P_LF;
      else if (cf == sef_pkg::FLD_DATA) p = sef_pkg::P_DATA_EMPTY;
      else p = sef_pkg::P_CMT_EMPTY;
    end else if (cf >= sef_pkg::FLD_EVENT && cf <= sef_pkg::FLD_RETRY) begin
      p = sef_pkg::P_LF;
    end else begin
      p = sef_pkg::P_NONE;
    end
    return p;
  endfunction

  always_comb begin
    logic [2:0]      t;
    logic [7:0]      b;
    logic            is_nl;
    sef_pkg::piece_e cp;
    t     = item_i.req_type;
    b     = item_i.in_byte;
    is_nl = (b == sef_pkg::CH_CR) || (b == sef_pkg::CH_LF);
    cp    = sef_pkg::P_NONE;

    cur_field_d = cur_field_q;
    line_open_d = line_open_q;
    seg_ne_d    = seg_ne_q;
    after_cr_d  = after_cr_q;
    any_d       = any_q;
    rej_d       = rej_q;
    bld.n       = 3'd0;
    bld.cmd.data = b;
    for (int i = 0; i < sef_pkg::NumSlots; i++) bld.cmd.pcs[i] = sef_pkg::P_NONE;

    if (t == sef_pkg::REQ_END) begin
      if (rej_q) begin
        bld = add_piece(bld, sef_pkg::P_REJECT);
      end else begin
        cp  = close_piece(cur_field_q, seg_ne_q);
        bld = add_piece(bld, cp);
        if (!any_q && cp == sef_pkg::P_NONE) bld = add_piece(bld, sef_pkg::P_CMT_EMPTY);
        bld = add_piece(bld, sef_pkg::P_LF);
      end
      cur_field_d = sef_pkg::FLD_NONE;
      line_open_d = 1'b0;
      seg_ne_d    = 1'b0;
      after_cr_d  = 1'b0;
      any_d       = 1'b0;
      rej_d       = 1'b0;
    end else if (t < sef_pkg::REQ_END && !rej_q) begin
      // switching to another field abandons the open one
      if (cur_field_d != t + 3'd1) begin
        cur_field_d = t + 3'd1;
        line_open_d = 1'b0;
        seg_ne_d    = 1'b0;
        after_cr_d  = 1'b0;
      end
      if (t >= sef_pkg::REQ_EVENT && t <= sef_pkg::REQ_RETRY) begin
        if (item_i.has_byte && t != sef_pkg::REQ_RETRY && is_nl) begin
          rej_d       = 1'b1;
          cur_field_d = sef_pkg::FLD_NONE;
          line_open_d = 1'b0;
          seg_ne_d    = 1'b0;
          after_cr_d  = 1'b0;
        end else begin
          if (!line_open_d) begin
            if (t == sef_pkg::REQ_EVENT) bld = add_piece(bld, sef_pkg::P_EVENT_PFX);
            else if (t == sef_pkg::REQ_ID) bld = add_piece(bld, sef_pkg::P_ID_PFX);
            else bld = add_piece(bld, sef_pkg::P_RETRY_PFX);
            line_open_d = 1'b1;
          end
          if (item_i.has_byte) bld = add_piece(bld, sef_pkg::P_BYTE);
        end
      end else if (item_i.has_byte) begin
        if (after_cr_d && b == sef_pkg::CH_LF) begin
          // second half of crlf
          after_cr_d = 1'b0;
        end else if (is_nl) begin
          bld = add_piece(bld, close_piece(cur_field_d, seg_ne_d));
          seg_ne_d    = 1'b0;
          line_open_d = 1'b0;
          after_cr_d  = (b == sef_pkg::CH_CR);
        end else begin
          after_cr_d = 1'b0;
          if (!seg_ne_d) begin
            if (t == sef_pkg::REQ_DATA) bld = add_piece(bld, sef_pkg::P_DATA_TXT);
            else bld = add_piece(bld, sef_pkg::P_CMT_TXT);
            seg_ne_d    = 1'b1;
            line_open_d = 1'b1;
          end
          bld = add_piece(bld, sef_pkg::P_BYTE);
        end
      end
      if (item_i.last_of_field && !rej_d) begin
        bld = add_piece(bld, close_piece(cur_field_d, seg_ne_d));
        cur_field_d = sef_pkg::FLD_NONE;
        line_open_d = 1'b0;
        seg_ne_d    = 1'b0;
        after_cr_d  = 1'b0;
      end
      any_d = any_q | (bld.n != 3'd0);
    end
  end

  assign wr_en_o  = accept_i && (bld.n != 3'd0);
  assign wr_cmd_o = bld.cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_field_q <= sef_pkg::FLD_NONE;
      line_open_q <= 1'b0;
      seg_ne_q    <= 1'b0;
      after_cr_q  <= 1'b0;
      any_q       <= 1'b0;
      rej_q       <= 1'b0;
    end else if (accept_i) begin
      cur_field_q <= cur_field_d;
      line_open_q <= line_open_d;
      seg_ne_q    <= seg_ne_d;
      after_cr_q  <= after_cr_d;
      any_q       <= any_d;
      rej_q       <= rej_d;
    end
  end

  // a rejected frame never keeps a field open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej_q |-> (cur_field_q == sef_pkg::FLD_NONE && !seg_ne_q && !line_open_q))
    else $error("rejected frame with open field");

endmodule

FILE: hdl/sef_cmd_queue.sv
module sef_cmd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  sef_pkg::cmd_t wr_cmd_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output logic          rd_valid_o,
  output sef_pkg::cmd_t rd_cmd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  sef_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (cnt_q == CW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_ptr_q] <= wr_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (rd_en_i) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (wr_en_i && !rd_en_i) cnt_q <= cnt_q + 1'b1;
      else if (!wr_en_i && rd_en_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (!full_o || rd_en_i))
    else $error("command written into full queue");

endmodule

FILE: hdl/sef_back.sv
module sef_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_valid_i,
  input  sef_pkg::cmd_t      rd_cmd_i,
  output logic               rd_en_o,
  output sef_pkg::out_item_t out_item_o,
  output logic               empty,
  input  logic               pop
);

  logic [sef_pkg::SlotW-1:0] slot_q, slot_d, nxt_slot;
  logic [2:0]                idx_q, idx_d;
  logic                      out_valid_q;
  sef_pkg::out_item_t        out_q;
  sef_pkg::piece_e           cur_p;
  logic                      last_char, last_piece, adv, step;

  always_comb begin
    cur_p      = rd_cmd_i.pcs[slot_q];
    nxt_slot   = slot_q + 1'b1;
    last_char  = (idx_q == sef_pkg::piece_len(cur_p) - 3'd1);
    last_piece = (slot_q == sef_pkg::SlotW'(sef_pkg::NumSlots - 1)) ||
                 (rd_cmd_i.pcs[nxt_slot] == sef_pkg::P_NONE);
    adv        = !out_valid_q || pop;
    step       = adv && rd_valid_i;
    slot_d     = slot_q;
    idx_d      = idx_q;
    if (step) begin
      if (!last_char) begin
        idx_d = idx_q + 3'd1;
      end else if (last_piece) begin
        slot_d = '0;
        idx_d  = 3'd0;
      end else begin
        slot_d = nxt_slot;
        idx_d  = 3'd0;
      end
    end
  end

  assign rd_en_o    = step && last_char && last_piece;
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      idx_q  <= idx_d;
      if (adv) out_valid_q <= rd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.out_byte <= sef_pkg::piece_char(cur_p, idx_q, rd_cmd_i.data);
      out_q.run_last <= last_char && last_piece;
      out_q.reject   <= (cur_p == sef_pkg::P_REJECT);
    end
  end

  // reject marker is always the only result of its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.reject) |-> out_q.run_last)
    else $error("reject marker not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(out_q)))
    else $error("waiting result changed");

endmodule

FILE: hdl/sse_event_framer_core.sv
// server-sent events framer
// input channel: one field item per transaction on in_item_i (type, byte,
// has_byte, last_of_field); a transaction happens when push is high and full
// is low. result channel: one frame byte per transaction on out_item_o; the
// oldest byte is shown while empty is low and is taken when pop is high.
// run_last marks the final byte caused by an input item, reject marks the
// single marker byte that ends a refused frame.
// the first byte of an item passes the command queue and then the result
// register before it shows on the result ports. the byte emitter puts out
// one byte per cycle while the receiver keeps up, and works on an item until
// all its bytes are out (at most 12); items making one byte or none go at one
// per cycle while nothing stalls. line prefixes and closing lines are absorbed
// by a CmdDepth entry command queue; full rises only when that queue is full.
// when the receiver stalls the result byte holds and the queue fills, then
// full backpressures the sender.
// reset clears all framing state and empties the queue and the result register;
// the block is ready in the first cycle after reset.
module sse_event_framer_core #(
  parameter int unsigned CmdDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sef_pkg::in_item_t  in_item_i,
  input  logic               push,
  output logic               full,
  output sef_pkg::out_item_t out_item_o,
  output logic               empty,
  input  logic               pop
);

  logic          accept;
  logic          wr_en;
  sef_pkg::cmd_t wr_cmd;
  logic          rd_en;
  logic          rd_valid;
  sef_pkg::cmd_t rd_cmd;

  assign accept = push && !full;

  sef_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_item_i),
    .accept_i (accept),
    .wr_en_o  (wr_en),
    .wr_cmd_o (wr_cmd)
  );

  sef_cmd_queue #(
    .Depth (CmdDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_cmd_i   (wr_cmd),
    .full_o     (full),
    .rd_en_i    (rd_en),
    .rd_valid_o (rd_valid),
    .rd_cmd_o   (rd_cmd)
  );

  sef_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (rd_valid),
    .rd_cmd_i   (rd_cmd),
    .rd_en_o    (rd_en),
    .out_item_o (out_item_o),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
